>>> sv/assert_macros.svh
// assertion macros shared by the pwm controller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("pwm controller check failed");

// when a holds, b holds in the next cycle
`define ASSERT_IMPLY_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("pwm controller check failed");

`endif

>>> sv/pwmc_pkg.sv
// types, constants and decode helpers for the pwm controller
`default_nettype none
package pwmc_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int PWM_BITS     = 12;
	localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CH_BYTES     = 4 * NUM_CHANNELS;

	localparam logic [7:0] ADDR_MODE     = 8'h00;
	localparam logic [7:0] ADDR_CH_BASE  = 8'h06;
	localparam int         CH_END        = 6 + CH_BYTES;
	localparam logic [7:0] ADDR_ALL_BASE = 8'hFA;
	localparam logic [7:0] ADDR_ALL_LAST = 8'hFD;
	localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

	localparam int MODE_RESTART_BIT = 7;
	localparam int MODE_AI_BIT      = 5;
	localparam int MODE_SLEEP_BIT   = 4;
	localparam int FULL_BIT         = 4;

	localparam logic [7:0] MODE_RST     = 8'h10;
	localparam logic [7:0] PRESCALE_RST = 8'd30;

	// byte position inside a channel
	localparam logic [1:0] K_ON_L  = 2'd0;
	localparam logic [1:0] K_ON_H  = 2'd1;
	localparam logic [1:0] K_OFF_L = 2'd2;
	localparam logic [1:0] K_OFF_H = 2'd3;

	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_WR_BYTE = 2'd1;
	localparam logic [1:0] OP_WR_WORD = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	typedef logic [PWM_BITS-1:0] cnt_t;

	typedef struct packed {
		logic                is_mode;
		logic                is_ch;
		logic                is_all;
		logic                is_pre;
		logic [CH_IDX_W-1:0] ch;
		logic [1:0]          k;
	} dec_t;

	typedef struct packed {
		logic        upd;
		logic [1:0]  op;
		logic [7:0]  addr;
		logic [15:0] wdata;
	} req_t;

	typedef struct packed {
		logic full_on;
		logic full_off;
		cnt_t on;
		cnt_t off;
	} chan_t;

	function automatic dec_t decode(input logic [7:0] a);
		logic [7:0] idx;
		logic [7:0] ka;
		dec_t       d;
		idx       = a - ADDR_CH_BASE;
		ka        = a - ADDR_ALL_BASE;
		d.is_mode = (a == ADDR_MODE);
		d.is_ch   = (a >= ADDR_CH_BASE) && ({1'b0, a} < 9'(CH_END));
		d.is_all  = (a >= ADDR_ALL_BASE) && (a <= ADDR_ALL_LAST);
		d.is_pre  = (a == ADDR_PRESCALE);
		d.ch      = idx[CH_IDX_W+1:2];
		d.k       = d.is_all ? ka[1:0] : idx[1:0];
		return d;
	endfunction

	// restart clears on a written one and sets when going to sleep
	function automatic logic [7:0] mode_put(input logic [7:0] m, input logic [7:0] v);
		logic restart;
		restart = m[MODE_RESTART_BIT];
		if (v[MODE_RESTART_BIT])
			restart = 1'b0;
		if (!m[MODE_SLEEP_BIT] && v[MODE_SLEEP_BIT])
			restart = 1'b1;
		return {restart, 1'b0, v[MODE_AI_BIT], v[MODE_SLEEP_BIT], 4'b0000};
	endfunction

	function automatic cnt_t time_of(input logic [4:0] hi, input logic [7:0] lo);
		logic [11:0] raw;
		raw = {hi[3:0], lo};
		return cnt_t'(raw);
	endfunction

endpackage
`default_nettype wire

>>> sv/pwmc_regfile.sv
// register file, prescaler and pwm counter of the pwm controller
`default_nettype none
`include "assert_macros.svh"
module pwmc_regfile
	import pwmc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	output logic [7:0] rd_data,
	output chan_t      chan [NUM_CHANNELS],
	output cnt_t       pwm_cnt
);

	logic [7:0] on_l_q  [NUM_CHANNELS];
	logic [4:0] on_h_q  [NUM_CHANNELS];
	logic [7:0] off_l_q [NUM_CHANNELS];
	logic [4:0] off_h_q [NUM_CHANNELS];
	logic [7:0] on_l_d  [NUM_CHANNELS];
	logic [4:0] on_h_d  [NUM_CHANNELS];
	logic [7:0] off_l_d [NUM_CHANNELS];
	logic [4:0] off_h_d [NUM_CHANNELS];

	logic [7:0] mode_q, mode_mid, mode_d;
	logic [7:0] pre_q, pre_d;
	logic [7:0] pcnt_q, pcnt_d;
	cnt_t       pwm_cnt_q, pwm_cnt_d;

	dec_t       d1, d2, dr;
	logic [7:0] a2, v1, v2;
	logic       wr1, wr2, tick;

	function automatic logic hit(input dec_t d, input int c, input logic [1:0] k);
		return (d.is_all && d.k == k) ||
			(d.is_ch && d.ch == CH_IDX_W'(c) && d.k == k);
	endfunction

	always_comb begin
		v1   = req.wdata[7:0];
		v2   = req.wdata[15:8];
		wr1  = req.upd && (req.op == OP_WR_BYTE || req.op == OP_WR_WORD);
		wr2  = req.upd && (req.op == OP_WR_WORD);
		tick = req.upd && (req.op == OP_TICK) && !mode_q[MODE_SLEEP_BIT];
		d1   = decode(req.addr);

		// first byte may change auto-increment before the second lands
		mode_mid = (wr1 && d1.is_mode) ? mode_put(mode_q, v1) : mode_q;
		a2       = mode_mid[MODE_AI_BIT] ? req.addr + 8'd1 : req.addr;
		d2       = decode(a2);
		mode_d   = (wr2 && d2.is_mode) ? mode_put(mode_mid, v2) : mode_mid;

		pre_d = pre_q;
		if (wr1 && d1.is_pre && mode_q[MODE_SLEEP_BIT])
			pre_d = v1;
		if (wr2 && d2.is_pre && mode_mid[MODE_SLEEP_BIT])
			pre_d = v2;

		for (int c = 0; c < NUM_CHANNELS; c++) begin
			on_l_d[c]  = on_l_q[c];
			on_h_d[c]  = on_h_q[c];
			off_l_d[c] = off_l_q[c];
			off_h_d[c] = off_h_q[c];
			if (wr1 && hit(d1, c, K_ON_L))  on_l_d[c]  = v1;
			if (wr1 && hit(d1, c, K_ON_H))  on_h_d[c]  = v1[4:0];
			if (wr1 && hit(d1, c, K_OFF_L)) off_l_d[c] = v1;
			if (wr1 && hit(d1, c, K_OFF_H)) off_h_d[c] = v1[4:0];
			if (wr2 && hit(d2, c, K_ON_L))  on_l_d[c]  = v2;
			if (wr2 && hit(d2, c, K_ON_H))  on_h_d[c]  = v2[4:0];
			if (wr2 && hit(d2, c, K_OFF_L)) off_l_d[c] = v2;
			if (wr2 && hit(d2, c, K_OFF_H)) off_h_d[c] = v2[4:0];
		end

		pcnt_d    = pcnt_q;
		pwm_cnt_d = pwm_cnt_q;
		if (tick) begin
			if (pcnt_q >= pre_q) begin
				pcnt_d    = 8'd0;
				pwm_cnt_d = pwm_cnt_q + cnt_t'(1);
			end else begin
				pcnt_d = pcnt_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RST;
			pre_q     <= PRESCALE_RST;
			pcnt_q    <= 8'd0;
			pwm_cnt_q <= '0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				on_l_q[c]  <= 8'd0;
				on_h_q[c]  <= 5'd0;
				off_l_q[c] <= 8'd0;
				off_h_q[c] <= 5'h10;
			end
		end else begin
			mode_q    <= mode_d;
			pre_q     <= pre_d;
			pcnt_q    <= pcnt_d;
			pwm_cnt_q <= pwm_cnt_d;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				on_l_q[c]  <= on_l_d[c];
				on_h_q[c]  <= on_h_d[c];
				off_l_q[c] <= off_l_d[c];
				off_h_q[c] <= off_h_d[c];
			end
		end
	end

	// byte read, all-led and unmapped addresses give zero
	always_comb begin
		dr      = decode(req.addr);
		rd_data = 8'd0;
		if (dr.is_mode) begin
			rd_data = mode_q;
		end else if (dr.is_pre) begin
			rd_data = pre_q;
		end else if (dr.is_ch) begin
			case (dr.k)
				K_ON_L:  rd_data = on_l_q[dr.ch];
				K_ON_H:  rd_data = {3'b000, on_h_q[dr.ch]};
				K_OFF_L: rd_data = off_l_q[dr.ch];
				K_OFF_H: rd_data = {3'b000, off_h_q[dr.ch]};
				default: rd_data = 8'd0;
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			chan[c].full_on  = on_h_q[c][FULL_BIT];
			chan[c].full_off = off_h_q[c][FULL_BIT];
			chan[c].on       = time_of(on_h_q[c], on_l_q[c]);
			chan[c].off      = time_of(off_h_q[c], off_l_q[c]);
		end
	end

	assign pwm_cnt = pwm_cnt_q;

	`ASSERT_IMPLY_NEXT(a_sleep_holds_count, mode_q[MODE_SLEEP_BIT], $stable(pwm_cnt_q))
	`ASSERT_IMPLY_NEXT(a_idle_holds_regs, !req.upd, $stable(mode_q) && $stable(pre_q))

endmodule
`default_nettype wire

>>> sv/sixteen_channel_pwm_controller.sv
// top level of the sixteen-channel pwm controller: stream ports and pipeline
//
//  channel  dir  tdata (low bit first)         tuser
//  s_*      in   addr[7:0], wdata[23:8]        op[1:0]
//  m_*      out  read_data[7:0], pwm_out[23:8] -
//
// one beat per cycle sustained while m_tready holds; a beat passes through the
// input register, the register-file update and the output register to m_tvalid.
// arst_n clears all valid bits and puts the registers to their reset values.
// stages move forward independently, so input keeps flowing into empty
// stages while a result waits on m_tready.
`default_nettype none
`include "assert_macros.svh"
module sixteen_channel_pwm_controller
	import pwmc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // addr[7:0], wdata[23:8]
	input  wire logic [1:0]  s_tuser,  // op[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata   // read_data[7:0], pwm_out[23:8]
);

	logic        valid_s1, valid_s2, out_v_q;
	logic [1:0]  op_s1, op_s2;
	logic [7:0]  addr_s1;
	logic [15:0] wdata_s1;
	logic [7:0]  rd_s2, out_rd_q;
	logic [15:0] out_pwm_q, lvl;
	logic        out_adv, s2_adv, s1_adv;
	logic [7:0]  rd_data;
	chan_t       chan [NUM_CHANNELS];
	cnt_t        pwm_cnt;
	req_t        req;

	assign out_adv  = !out_v_q || m_tready;
	assign s2_adv   = !valid_s2 || out_adv;
	assign s1_adv   = !valid_s1 || s2_adv;
	assign s_tready = s1_adv;

	// state changes only when a beat moves from s1 into s2
	assign req.upd   = valid_s1 && s2_adv;
	assign req.op    = op_s1;
	assign req.addr  = addr_s1;
	assign req.wdata = wdata_s1;

	pwmc_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data),
		.chan    (chan),
		.pwm_cnt (pwm_cnt)
	);

	// levels see the state left by the beat in s2
	always_comb begin
		lvl = 16'd0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (chan[c].full_off)
				lvl[c] = 1'b0;
			else if (chan[c].full_on)
				lvl[c] = 1'b1;
			else if (chan[c].on == chan[c].off)
				lvl[c] = 1'b0;
			else if (chan[c].on < chan[c].off)
				lvl[c] = (pwm_cnt >= chan[c].on) && (pwm_cnt < chan[c].off);
			else
				lvl[c] = (pwm_cnt >= chan[c].on) || (pwm_cnt < chan[c].off);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (s1_adv)
				valid_s1 <= s_tvalid;
			if (s2_adv)
				valid_s2 <= valid_s1;
			if (out_adv)
				out_v_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s_tvalid) begin
			op_s1    <= s_tuser;
			addr_s1  <= s_tdata[7:0];
			wdata_s1 <= s_tdata[23:8];
		end
		if (req.upd) begin
			op_s2 <= op_s1;
			rd_s2 <= (op_s1 == OP_READ) ? rd_data : 8'd0;
		end
		if (out_adv && valid_s2) begin
			out_rd_q  <= rd_s2;
			out_pwm_q <= lvl;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_pwm_q, out_rd_q};

	`ASSERT_ALWAYS(a_ready_when_out_empty, out_v_q || s_tready)
	`ASSERT_ALWAYS(a_rd_only_on_read, !(valid_s2 && op_s2 != OP_READ && rd_s2 != 8'd0))

endmodule
`default_nettype wire
